// File: sv/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, codes and helpers of the periodic timer scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int TIME_BITS_DEF  = 20;

   localparam int TAG_W   = 16;
   localparam int MODE_W  = 2;
   localparam int DELAY_W = 20;
   localparam int SLOT_W  = 4;
   localparam int KIND_W  = 2;

   localparam logic [MODE_W-1:0] MODE_ONE_SHOT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIXED_RATE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FIXED_DLY  = 2'd2;

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_TICK     = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPT   = 2'd0,
      KIND_FULL     = 2'd1,
      KIND_DISPATCH = 2'd2
   } kind_type;

   typedef struct packed {
      logic cap;
      logic sched_wr;
      logic full;
      logic rd;
      logic ev;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic due;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

   function automatic logic is_periodic(input logic [MODE_W-1:0] m);
      return m inside {MODE_FIXED_RATE, MODE_FIXED_DLY};
   endfunction

endpackage

// File: sv/pts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_datapath
// Timer table storage, scan pipeline, pending result and output register.
// ----------------------------------------------------------------------------
module pts_datapath #(
   parameter int NUM_TIMERS = pts_pkg::NUM_TIMERS_DEF,
   parameter int TIME_BITS  = pts_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pts_pkg::ctl_cmd_type              cmd,
   input  logic [$clog2(NUM_TIMERS)-1:0]     idx,
   output pts_pkg::dp_status_type            status,
   input  logic [pts_pkg::TAG_W-1:0]         req_task_tag,
   input  logic [pts_pkg::MODE_W-1:0]        req_mode,
   input  logic [pts_pkg::DELAY_W-1:0]       req_first_delay,
   input  logic [pts_pkg::DELAY_W-1:0]       req_interval,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pts_pkg::KIND_W-1:0]        rsp_kind,
   output logic [pts_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [pts_pkg::TAG_W-1:0]         rsp_dispatched_tag,
   output logic                              rsp_last
);
   import pts_pkg::*;

   localparam int IDX_W = $clog2(NUM_TIMERS);

   logic [TAG_W-1:0]     tag_ff;
   logic [MODE_W-1:0]    mode_ff;
   logic [TIME_BITS-1:0] delay_ff;
   logic [TIME_BITS-1:0] ivl_ff;

   logic [TAG_W-1:0]     tag_mem  [NUM_TIMERS];
   logic [MODE_W-1:0]    mode_mem [NUM_TIMERS];
   logic [TIME_BITS-1:0] rem_mem  [NUM_TIMERS];
   logic [TIME_BITS-1:0] ivl_mem  [NUM_TIMERS];

   logic [TAG_W-1:0]     rd_tag_ff;
   logic [MODE_W-1:0]    rd_mode_ff;
   logic [TIME_BITS-1:0] rd_rem_ff;
   logic [TIME_BITS-1:0] rd_ivl_ff;
   logic [IDX_W-1:0]     ev_idx_ff;

   logic [NUM_TIMERS-1:0] valid_ff, valid_in;

   logic                 pend_valid_ff, pend_valid_in;
   kind_type             pend_kind_ff;
   logic [SLOT_W-1:0]    pend_slot_ff;
   logic [TAG_W-1:0]     pend_tag_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [TAG_W-1:0]     rsp_tag_ff;
   logic                 rsp_last_ff;

   logic                 ev_entry_valid;
   logic                 due;
   logic                 periodic;
   logic [TIME_BITS-1:0] reload;
   logic                 rem_we;
   logic [IDX_W-1:0]     rem_addr;
   logic [TIME_BITS-1:0] rem_wdata;
   logic                 out_load;
   logic                 out_free;

   assign ev_entry_valid = valid_ff[ev_idx_ff];
   assign due            = ev_entry_valid && (rd_rem_ff == '0);
   assign periodic       = is_periodic(rd_mode_ff);
   assign reload         = (rd_ivl_ff == '0) ? '0 : rd_ivl_ff - TIME_BITS'(1);

   assign rem_we   = cmd.sched_wr || (cmd.ev && ev_entry_valid);
   assign rem_addr = cmd.sched_wr ? idx : ev_idx_ff;

   always_comb begin
      if (cmd.sched_wr) begin
         rem_wdata = delay_ff;
      end else if (due) begin
         rem_wdata = reload;
      end else begin
         rem_wdata = rd_rem_ff - TIME_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         tag_ff   <= req_task_tag;
         mode_ff  <= req_mode;
         delay_ff <= TIME_BITS'(req_first_delay);
         ivl_ff   <= TIME_BITS'(req_interval);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sched_wr) begin
         tag_mem[idx]  <= tag_ff;
         mode_mem[idx] <= mode_ff;
         ivl_mem[idx]  <= ivl_ff;
      end
      if (rem_we) begin
         rem_mem[rem_addr] <= rem_wdata;
      end
      if (cmd.rd) begin
         rd_tag_ff  <= tag_mem[idx];
         rd_mode_ff <= mode_mem[idx];
         rd_rem_ff  <= rem_mem[idx];
         rd_ivl_ff  <= ivl_mem[idx];
         ev_idx_ff  <= idx;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.sched_wr) begin
         valid_in[idx] = 1'b1;
      end
      if (cmd.ev && due && !periodic) begin
         valid_in[ev_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // pending beat: held back until the next one (or scan end) decides last
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = pend_valid_ff && ((cmd.ev && due) || cmd.flush);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
      if (cmd.sched_wr || cmd.full || (cmd.ev && due)) begin
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sched_wr) begin
         pend_kind_ff <= KIND_ACCEPT;
         pend_slot_ff <= SLOT_W'(idx);
         pend_tag_ff  <= tag_ff;
      end else if (cmd.full) begin
         pend_kind_ff <= KIND_FULL;
         pend_slot_ff <= '0;
         pend_tag_ff  <= '0;
      end else if (cmd.ev && due) begin
         pend_kind_ff <= KIND_DISPATCH;
         pend_slot_ff <= SLOT_W'(ev_idx_ff);
         pend_tag_ff  <= rd_tag_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_slot_ff <= pend_slot_ff;
         rsp_tag_ff  <= pend_tag_ff;
         rsp_last_ff <= cmd.flush;
      end
   end

   assign status.slot_free  = !valid_ff[idx];
   assign status.due        = due;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_dispatched_tag = rsp_tag_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// File: sv/pts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer for schedule and tick scans over the timer table.
// ----------------------------------------------------------------------------
module pts_ctrl #(
   parameter int NUM_TIMERS = pts_pkg::NUM_TIMERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_command,
   output logic                          req_stall,
   output pts_pkg::ctl_cmd_type          cmd,
   output logic [$clog2(NUM_TIMERS)-1:0] idx,
   input  pts_pkg::dp_status_type        status
);
   import pts_pkg::*;

   localparam int IDX_W = $clog2(NUM_TIMERS);
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCHED = 4'b0010,
      ST_TICK  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             ev_valid_ff, ev_valid_in;
   logic             at_end;
   logic             hold;

   assign at_end = (idx_ff == CNT_W'(NUM_TIMERS));
   assign hold   = ev_valid_ff && status.due && status.pend_valid && !status.out_free;
   assign idx    = idx_ff[IDX_W-1:0];

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      ev_valid_in = ev_valid_ff;
      cmd         = '0;
      req_stall   = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.cap     = 1'b1;
               idx_in      = '0;
               ev_valid_in = 1'b0;
               state_in    = (req_command == CMD_TICK) ? ST_TICK : ST_SCHED;
            end
         end
         ST_SCHED: begin
            if (at_end) begin
               cmd.full = 1'b1;
               state_in = ST_FLUSH;
            end else if (status.slot_free) begin
               cmd.sched_wr = 1'b1;
               state_in     = ST_FLUSH;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_TICK: begin
            if (!hold) begin
               cmd.ev = ev_valid_ff;
               if (!at_end) begin
                  cmd.rd      = 1'b1;
                  idx_in      = idx_ff + CNT_W'(1);
                  ev_valid_in = 1'b1;
               end else begin
                  ev_valid_in = 1'b0;
                  if (!ev_valid_ff) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         ev_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         ev_valid_ff <= ev_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= CNT_W'(NUM_TIMERS))
      else $error("scan index past table end");

   a_flush_free: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> status.out_free)
      else $error("last beat pushed into busy output");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.ev && status.due && status.pend_valid) |-> status.out_free)
      else $error("dispatch beat pushed into busy output");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted item did not start work");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sched_wr && (cmd.rd || cmd.ev)))
      else $error("schedule write overlaps tick scan");
`endif

endmodule

// File: sv/periodic_timer_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_scheduler
// Table of countdown timers with one-shot and periodic dispatch.
// ----------------------------------------------------------------------------
// One item at a time. A schedule searches the slots one per cycle for the lowest
// free one and takes it, or answers full when the table is full. A tick walks the
// table through the single read port of the timer memory, one slot per cycle while
// the result side does not stall. Either item waits while the result side stalls.
// Each dispatch beat is held in the pending register until the next beat or the
// scan end, so the final beat of a tick can carry last.
module periodic_timer_scheduler #(
   parameter int NUM_TIMERS = pts_pkg::NUM_TIMERS_DEF,
   parameter int TIME_BITS  = pts_pkg::TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [pts_pkg::TAG_W-1:0]    req_task_tag,
   input  logic [pts_pkg::MODE_W-1:0]   req_mode,
   input  logic [pts_pkg::DELAY_W-1:0]  req_first_delay,
   input  logic [pts_pkg::DELAY_W-1:0]  req_interval,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pts_pkg::KIND_W-1:0]   rsp_kind,
   output logic [pts_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [pts_pkg::TAG_W-1:0]    rsp_dispatched_tag,
   output logic                         rsp_last
);
   import pts_pkg::*;

   localparam int IDX_W = $clog2(NUM_TIMERS);

   ctl_cmd_type      cmd;
   dp_status_type    status;
   logic [IDX_W-1:0] idx;

   pts_ctrl #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .cmd         (cmd),
      .idx         (idx),
      .status      (status)
   );

   pts_datapath #(
      .NUM_TIMERS (NUM_TIMERS),
      .TIME_BITS  (TIME_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .idx                (idx),
      .status             (status),
      .req_task_tag       (req_task_tag),
      .req_mode           (req_mode),
      .req_first_delay    (req_first_delay),
      .req_interval       (req_interval),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_slot           (rsp_slot),
      .rsp_dispatched_tag (rsp_dispatched_tag),
      .rsp_last           (rsp_last)
   );

endmodule
